/* rtl/tbs_pkg.sv */
// tbs_pkg: shared types, sizes and codes of the token bucket shaper
// used by every module in rtl, depends on nothing
package tbs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_TOO_BIG   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_TOKEN_ADD = 3'd3;
  localparam logic [2:0] ST_TOKEN_DRP = 3'd4;
  localparam logic [2:0] ST_FLUSHED   = 3'd5;

  localparam logic [1:0] ACT_ARRIVAL = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;

  localparam logic [15:0] DEPTH_RESET = 16'd10;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] packet_id;
    logic [15:0] token_need;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        release_valid;
    logic [15:0] release_id;
    logic [15:0] release_tokens;
    logic [15:0] bucket_level;
    logic [4:0]  queue_count;
    logic [4:0]  flushed_count;
  } out_word_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [15:0]         tokens;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t wdata;
  } q_ctrl_t;

endpackage

/* rtl/tbs_in_reg.sv */
// tbs_in_reg: input register stage holding one word
// depends on tbs_pkg
module tbs_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tbs_pkg::in_word_t in_word_i,
  input  logic              advance_i,
  output logic              valid_o,
  output tbs_pkg::in_word_t word_o
);
  import tbs_pkg::*;

  logic     valid_q;
  in_word_t word_q;

  assign in_stall_o = valid_q && !advance_i;
  assign valid_o    = valid_q;
  assign word_o     = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= in_word_i;
    end
  end

endmodule

/* rtl/tbs_queue.sv */
// tbs_queue: waiting queue storage with head and tail pointers and fill count
// depends on tbs_pkg
module tbs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbs_pkg::q_ctrl_t ctrl_i,
  output tbs_pkg::entry_t  head_o,
  output logic [tbs_pkg::CNT_W-1:0] count_o
);
  import tbs_pkg::*;

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o  = mem_q[head_q];
  assign count_o = count_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (ctrl_i.push) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d  = next_ptr(head_q);
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      mem_q[tail_q] <= ctrl_i.wdata;
    end
  end

endmodule

/* rtl/tbs_shaper.sv */
// tbs_shaper: bucket depth register, token level and per-word decision logic
// depends on tbs_pkg, drives tbs_queue through a q_ctrl_t
module tbs_shaper (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [15:0]               cfg_wdata_i,
  input  logic                      advance_i,
  input  tbs_pkg::in_word_t         word_i,
  input  tbs_pkg::entry_t           head_i,
  input  logic [tbs_pkg::CNT_W-1:0] count_i,
  output tbs_pkg::q_ctrl_t          ctrl_o,
  output tbs_pkg::out_word_t        res_o
);
  import tbs_pkg::*;

  logic [15:0]      depth_q;
  logic [15:0]      level_q, level_d;
  logic [15:0]      level_inc;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      pid_ext;
  logic [31:0]      rel_ext;
  entry_t           rel_entry;
  q_ctrl_t          ctrl;

  assign pid_ext   = 32'(word_i.packet_id);
  assign level_inc = (level_q < depth_q) ? level_q + 16'd1 : level_q;

  always_comb begin
    ctrl              = '0;
    ctrl.wdata.id     = pid_ext[ID_WIDTH-1:0];
    ctrl.wdata.tokens = word_i.token_need;
    rel_entry         = '0;
    level_d           = level_q;
    res_o             = '0;
    if (word_i.action[1]) begin
      ctrl.clear          = 1'b1;
      res_o.status        = ST_FLUSHED;
      res_o.flushed_count = 5'(32'(count_i));
    end else if (word_i.action == ACT_TICK) begin
      res_o.status = (level_q < depth_q) ? ST_TOKEN_ADD : ST_TOKEN_DRP;
      level_d      = level_inc;
      if (count_i != '0 && head_i.tokens <= level_inc) begin
        ctrl.pop            = 1'b1;
        level_d             = level_inc - head_i.tokens;
        rel_entry           = head_i;
        res_o.release_valid = 1'b1;
      end
    end else begin
      if (word_i.token_need > depth_q) begin
        res_o.status = ST_TOO_BIG;
      end else if (count_i == CNT_W'(QUEUE_DEPTH)) begin
        res_o.status = ST_FULL;
      end else if (count_i == '0 && word_i.token_need <= level_q) begin
        res_o.status        = ST_QUEUED;
        level_d             = level_q - word_i.token_need;
        rel_entry           = ctrl.wdata;
        res_o.release_valid = 1'b1;
      end else begin
        res_o.status = ST_QUEUED;
        ctrl.push    = 1'b1;
      end
    end
    rel_ext              = 32'(rel_entry.id);
    res_o.release_id     = rel_ext[15:0];
    res_o.release_tokens = rel_entry.tokens;
    res_o.bucket_level   = level_d;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.push) begin
      count_next = count_i + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count_i - 1'b1;
    end else begin
      count_next = count_i;
    end
    res_o.queue_count = 5'(32'(count_next));
  end

  always_comb begin
    ctrl_o       = ctrl;
    ctrl_o.push  = ctrl.push && advance_i;
    ctrl_o.pop   = ctrl.pop && advance_i;
    ctrl_o.clear = ctrl.clear && advance_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      depth_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (advance_i) begin
      level_q <= level_d;
    end
  end

endmodule

/* rtl/token_bucket_shaper.sv */
// token_bucket_shaper: token bucket shaper with a waiting queue, top level
// an accepted word passes through the input register, then the result register
// one word per cycle sustained while out_stall_i is low; results leave in order
// reset clears the queue pointers, fill count and token level, bucket depth returns to 10
// depends on tbs_pkg, tbs_in_reg, tbs_queue and tbs_shaper
module token_bucket_shaper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbs_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbs_pkg::out_word_t  out_word_o
);
  import tbs_pkg::*;

  logic             stage_valid;
  in_word_t         stage_word;
  logic             advance;
  entry_t           head;
  logic [CNT_W-1:0] count;
  q_ctrl_t          ctrl;
  out_word_t        res;
  logic             out_valid_q;
  out_word_t        out_word_q;

  assign advance     = stage_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  tbs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .word_o     (stage_word)
  );

  tbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .head_o  (head),
    .count_o (count)
  );

  tbs_shaper u_shaper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .word_i      (stage_word),
    .head_i      (head),
    .count_i     (count),
    .ctrl_o      (ctrl),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res;
    end
  end

endmodule

/* bench/token_bucket_shaper_test.sv */
// token_bucket_shaper_test: self-checking bench for the token bucket shaper, a directed table
// then random phases over several bucket depths, every result word checked against the table or a predictor
// depends on tbs_pkg and the token_bucket_shaper rtl
module token_bucket_shaper_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbs_pkg::*;

  localparam logic [1:0] ACT_FLUSH    = 2'd2;
  localparam logic [1:0] ACT_FLUSH_HI = 2'd3;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SEG_ITEMS    = 35;
  localparam int PHASE_ITEMS  = 105;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_PHASES     = 9;

  localparam logic [15:0] PHASE_DEPTHS [N_PHASES] = '{
    16'd1, 16'd65535, 16'd4, 16'd0, 16'd16, 16'd2, 16'd300, 16'd3, 16'd10
  };

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg_val;
    in_word_t    word;
    bit          typed;
    out_word_t   res;
  } row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  in_word_t    in_word_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_word_t   out_word_o;

  bit          word_typed     = 1'b0;
  out_word_t   word_typed_res = '0;
  bit          tx_no_gaps     = 1'b0;
  bit          rx_no_gaps     = 1'b0;
  bit          hold_req       = 1'b0;

  // predictor state
  logic [15:0]      shadow_depth;
  logic [15:0]      shadow_level;
  entry_t           wait_ring [QUEUE_DEPTH];
  logic [PTR_W-1:0] ring_head;
  logic [PTR_W-1:0] ring_tail;
  logic [CNT_W-1:0] ring_fill;

  out_word_t pending_res [$];

  int mismatches = 0;
  int n_words    = 0;
  int n_settings = 0;
  int n_rel      = 0;
  int n_big      = 0;
  int n_full     = 0;
  int n_tdrop    = 0;
  int n_flush    = 0;
  int quiet      = 0;
  bit in_take;
  bit out_take;
  out_word_t want;

  token_bucket_shaper DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function void shadow_reset();
    shadow_depth = DEPTH_RESET;
    shadow_level = '0;
    ring_head    = '0;
    ring_tail    = '0;
    ring_fill    = '0;
  endfunction

  function out_word_t shape_event(in_word_t w);
    out_word_t r;
    entry_t    hd;
    r = '0;
    if (w.action == ACT_ARRIVAL) begin
      if (w.token_need > shadow_depth) begin
        r.status = ST_TOO_BIG;
      end else if (ring_fill >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else if (ring_fill == 0 && w.token_need <= shadow_level) begin
        r.status         = ST_QUEUED;
        shadow_level     = shadow_level - w.token_need;
        r.release_valid  = 1'b1;
        r.release_id     = w.packet_id;
        r.release_tokens = w.token_need;
      end else begin
        r.status                    = ST_QUEUED;
        wait_ring[ring_tail].id     = w.packet_id;
        wait_ring[ring_tail].tokens = w.token_need;
        ring_tail                   = ring_next(ring_tail);
        ring_fill                   = ring_fill + 1'b1;
      end
    end else if (w.action == ACT_TICK) begin
      if (shadow_level < shadow_depth) begin
        shadow_level = shadow_level + 1'b1;
        r.status     = ST_TOKEN_ADD;
      end else begin
        r.status = ST_TOKEN_DRP;
      end
      if (ring_fill != 0) begin
        hd = wait_ring[ring_head];
        if (hd.tokens <= shadow_level) begin
          shadow_level     = shadow_level - hd.tokens;
          r.release_valid  = 1'b1;
          r.release_id     = hd.id;
          r.release_tokens = hd.tokens;
          ring_head        = ring_next(ring_head);
          ring_fill        = ring_fill - 1'b1;
        end
      end
    end else begin
      r.status        = ST_FLUSHED;
      r.flushed_count = ring_fill;
      ring_fill       = '0;
      ring_head       = '0;
      ring_tail       = '0;
    end
    r.bucket_level = shadow_level;
    r.queue_count  = ring_fill;
    return r;
  endfunction

  task flag_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch on %s at word %0d: got %0h, wanted %0h", what, n_words, got, exp_val);
    mismatches++;
  endtask

  task check_word(out_word_t got, out_word_t w);
    if (got.status !== w.status)
      flag_mismatch("status", 32'(got.status), 32'(w.status));
    if (got.release_valid !== w.release_valid)
      flag_mismatch("release_valid", 32'(got.release_valid), 32'(w.release_valid));
    if (got.release_id !== w.release_id)
      flag_mismatch("release_id", 32'(got.release_id), 32'(w.release_id));
    if (got.release_tokens !== w.release_tokens)
      flag_mismatch("release_tokens", 32'(got.release_tokens), 32'(w.release_tokens));
    if (got.bucket_level !== w.bucket_level)
      flag_mismatch("bucket_level", 32'(got.bucket_level), 32'(w.bucket_level));
    if (got.queue_count !== w.queue_count)
      flag_mismatch("queue_count", 32'(got.queue_count), 32'(w.queue_count));
    if (got.flushed_count !== w.flushed_count)
      flag_mismatch("flushed_count", 32'(got.flushed_count), 32'(w.flushed_count));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_reset();
    end else begin
      in_take  = in_valid_i && !in_stall_o;
      out_take = out_valid_o && !out_stall_i;
      if (cfg_we_i) begin
        shadow_depth = cfg_wdata_i;
      end
      if (out_take) begin
        if (pending_res.size() == 0) begin
          flag_mismatch("unexpected word", 32'(out_word_o.status), '0);
        end else begin
          check_word(out_word_o, pending_res.pop_front());
        end
      end
      if (in_take) begin
        want = shape_event(in_word_i);
        if (word_typed) begin
          want = word_typed_res;
        end
        pending_res.push_back(want);
        n_words++;
        n_rel   += int'(want.release_valid);
        n_big   += int'(want.status == ST_TOO_BIG);
        n_full  += int'(want.status == ST_FULL);
        n_tdrop += int'(want.status == ST_TOKEN_DRP);
        n_flush += int'(want.status == ST_FLUSHED);
      end
      quiet = (in_take || out_take) ? 0 : quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("** token_bucket_shaper: FAILED **");
        $finish;
      end
    end
  end

  function automatic out_word_t mk_res(logic [2:0] st, logic rv, logic [15:0] id,
                                       logic [15:0] tok, logic [15:0] lvl,
                                       logic [4:0] qc, logic [4:0] fl);
    out_word_t r;
    r.status         = st;
    r.release_valid  = rv;
    r.release_id     = id;
    r.release_tokens = tok;
    r.bucket_level   = lvl;
    r.queue_count    = qc;
    r.flushed_count  = fl;
    return r;
  endfunction

  function automatic row_t word_row(logic [1:0] act, logic [15:0] id, logic [15:0] need,
                                    bit typed, out_word_t res);
    row_t r;
    r.is_cfg              = 1'b0;
    r.cfg_val             = '0;
    r.word.action         = act;
    r.word.packet_id      = id;
    r.word.token_need     = need;
    r.typed               = typed;
    r.res                 = res;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [15:0] v);
    row_t r;
    r         = word_row(ACT_TICK, '0, '0, 1'b0, '0);
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic in_word_t rand_word(mix_e mix, logic [15:0] depth);
    in_word_t    w;
    int          r;
    logic [15:0] cap;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  w.action = (r < 75) ? ACT_ARRIVAL : ACT_TICK;
      MIX_DRAIN: w.action = (r < 30) ? ACT_ARRIVAL : (r < 94) ? ACT_TICK : ACT_FLUSH;
      default:   w.action = (r < 45) ? ACT_ARRIVAL : (r < 88) ? ACT_TICK : ACT_FLUSH;
    endcase
    if (w.action == ACT_FLUSH && $urandom_range(0, 1) == 1) begin
      w.action = ACT_FLUSH_HI;
    end
    w.packet_id = 16'($urandom);
    cap = (depth < 16'd8) ? depth : 16'd8;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      w.token_need = 16'($urandom);
    end else if (r < 12) begin
      w.token_need = '0;
    end else if (r < 16) begin
      w.token_need = depth + 16'd1;
    end else if (r < 20) begin
      w.token_need = depth;
    end else begin
      w.token_need = 16'($urandom_range(0, int'(cap)));
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_word_i      <= w;
    word_typed     <= typed;
    word_typed_res <= res;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic cfg_write(logic [15:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  initial begin : sender
    row_t dir_tab [$];
    mix_e mix;
    dir_tab.push_back(word_row(ACT_TICK, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_TOKEN_ADD, 1'b0, 16'h0, 16'd0, 16'd1, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'hFFFF, 16'd0, 1'b1,
                               mk_res(ST_QUEUED, 1'b1, 16'hFFFF, 16'd0, 16'd1, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0001, 16'd11, 1'b1,
                               mk_res(ST_TOO_BIG, 1'b0, 16'h0, 16'd0, 16'd1, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0002, 16'hFFFF, 1'b1,
                               mk_res(ST_TOO_BIG, 1'b0, 16'h0, 16'd0, 16'd1, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0003, 16'd10, 1'b1,
                               mk_res(ST_QUEUED, 1'b0, 16'h0, 16'd0, 16'd1, 5'd1, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0004, 16'd0, 1'b0, '0));
    repeat (10) dir_tab.push_back(word_row(ACT_TICK, 16'h5A5A, 16'hA5A5, 1'b0, '0));
    dir_tab.push_back(word_row(ACT_FLUSH, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_FLUSHED, 1'b0, 16'h0, 16'd0, 16'd1, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0005, 16'd5, 1'b0, '0));
    dir_tab.push_back(word_row(ACT_FLUSH_HI, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_FLUSHED, 1'b0, 16'h0, 16'd0, 16'd1, 5'd0, 5'd1)));
    dir_tab.push_back(word_row(ACT_TICK, 16'h0000, 16'd0, 1'b0, '0));
    // depth lowered under the level
    dir_tab.push_back(cfg_row(16'd1));
    dir_tab.push_back(word_row(ACT_TICK, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_TOKEN_DRP, 1'b0, 16'h0, 16'd0, 16'd2, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0006, 16'd2, 1'b1,
                               mk_res(ST_TOO_BIG, 1'b0, 16'h0, 16'd0, 16'd2, 5'd0, 5'd0)));
    dir_tab.push_back(cfg_row(16'd0));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0007, 16'd1, 1'b1,
                               mk_res(ST_TOO_BIG, 1'b0, 16'h0, 16'd0, 16'd2, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'h0008, 16'd0, 1'b1,
                               mk_res(ST_QUEUED, 1'b1, 16'h0008, 16'd0, 16'd2, 5'd0, 5'd0)));
    dir_tab.push_back(word_row(ACT_TICK, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_TOKEN_DRP, 1'b0, 16'h0, 16'd0, 16'd2, 5'd0, 5'd0)));
    dir_tab.push_back(cfg_row(16'hFFFF));
    dir_tab.push_back(word_row(ACT_ARRIVAL, 16'hAAAA, 16'hFFFF, 1'b1,
                               mk_res(ST_QUEUED, 1'b0, 16'h0, 16'd0, 16'd2, 5'd1, 5'd0)));
    dir_tab.push_back(word_row(ACT_FLUSH, 16'h0000, 16'd0, 1'b1,
                               mk_res(ST_FLUSHED, 1'b0, 16'h0, 16'd0, 16'd2, 5'd0, 5'd1)));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        cfg_write(dir_tab[i].cfg_val);
      end else begin
        send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    mix = MIX_EVEN;
    for (int p = 0; p < N_PHASES; p++) begin
      cfg_write(PHASE_DEPTHS[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % SEG_ITEMS == 0) begin
          mix        = mix_e'($urandom_range(0, 2));
          tx_no_gaps = ($urandom_range(0, 3) == 0);
          // long receiver hold at the start of a segment that fills the queue
          if (p == 1 && n == 0) begin
            mix        = MIX_FILL;
            tx_no_gaps = 1'b1;
            hold_req   = 1'b1;
          end
        end
        send_word(rand_word(mix, PHASE_DEPTHS[p]), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d words over %0d depth settings: %0d releases, %0d too big, %0d full",
             n_words, n_settings, n_rel, n_big, n_full);
    $display("%0d token ticks dropped, %0d flushes, %0d mismatches",
             n_tdrop, n_flush, mismatches);
    if (mismatches == 0) begin
      $display("** token_bucket_shaper: PASSED **");
    end else begin
      $display("** token_bucket_shaper: FAILED **");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    int run;
    run = 0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (run == 0) begin
          rx_no_gaps = ($urandom_range(0, 3) == 0);
          run        = $urandom_range(20, 60);
        end
        run--;
        gap = rx_no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

endmodule

/* sim.f */
rtl/tbs_pkg.sv
rtl/tbs_in_reg.sv
rtl/tbs_queue.sv
rtl/tbs_shaper.sv
rtl/token_bucket_shaper.sv
bench/token_bucket_shaper_test.sv
